// File: sv/frs_pkg.sv
package frs_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int INDEX_BITS  = 24;

   // command queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // request kinds
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_EOF  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SYMBOL  = 2'd1;
   localparam logic [1:0] STATUS_SUMMARY = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_GT    = 8'h3e;
   localparam logic [7:0] CHAR_LT    = 8'h3c;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_N     = 8'h6e;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_Z     = 8'h7a;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      CMD_COUNT,
      CMD_CLOSE,
      CMD_EOF
   } cmd_op_type;

   // one classified beat for the back end
   typedef struct packed {
      cmd_op_type op;
      logic       open;    // EOF: a record is still open
      logic       nongap;
      logic       letter;
      logic       base;
      logic       amb;
      logic       forbid;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic logic [LENGTH_BITS-1:0] bump_len(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + LENGTH_BITS'(1);
   endfunction

   function automatic logic [INDEX_BITS-1:0] bump_idx(input logic [INDEX_BITS-1:0] v);
      return (&v) ? v : v + INDEX_BITS'(1);
   endfunction

endpackage

// File: sv/frs_req_if.sv
interface frs_req_if import frs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, req_type, data_byte, input ready);
   modport sink   (input valid, req_type, data_byte, output ready);
endinterface

// File: sv/frs_rsp_if.sv
interface frs_rsp_if import frs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [INDEX_BITS-1:0]  record_index;
   logic [LENGTH_BITS-1:0] seq_length;
   logic [LENGTH_BITS-1:0] nongap_length;
   logic [LENGTH_BITS-1:0] letter_count;
   logic [LENGTH_BITS-1:0] nucleotide_count;
   logic [LENGTH_BITS-1:0] n_count;
   logic [LENGTH_BITS-1:0] min_length;
   logic [LENGTH_BITS-1:0] max_length;
   logic [INDEX_BITS-1:0]  min_record;
   logic [INDEX_BITS-1:0]  max_record;
   logic                   last;

   modport source (output valid, status, record_index, seq_length, nongap_length,
                   letter_count, nucleotide_count, n_count, min_length, max_length,
                   min_record, max_record, last, input ready);
   modport sink   (input valid, status, record_index, seq_length, nongap_length,
                   letter_count, nucleotide_count, n_count, min_length, max_length,
                   min_record, max_record, last, output ready);
endinterface

// File: sv/frs_front.sv
module frs_front import frs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   frs_req_if.sink   req_ch,
   input  logic      csr_we,
   input  logic      csr_wdata,
   input  logic      queue_full,
   output push_type  push
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SEQ
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       line_start_ff, line_start_in;
   logic       check_ff;
   logic       accept;
   logic [7:0] c;
   logic [7:0] lc;
   logic       is_space;
   cmd_type    cmd;
   logic       produce;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.data_byte;

   always_comb begin
      lc       = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_BIT) : c;
      is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
                 (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);

      cmd.op     = CMD_COUNT;
      cmd.open   = (phase_ff == PH_HEADER) || (phase_ff == PH_SEQ);
      cmd.nongap = (c != CHAR_DASH);
      cmd.letter = (lc >= CHAR_A) && (lc <= CHAR_Z);
      cmd.base   = (lc == CHAR_A) || (lc == CHAR_C) || (lc == CHAR_G) ||
                   (lc == CHAR_T) || (lc == CHAR_U) || (lc == CHAR_N);
      cmd.amb    = (lc == CHAR_N);
      cmd.forbid = check_ff && ((c == CHAR_EQ) || (c == CHAR_LT) || (c == CHAR_GT));

      produce       = 1'b0;
      phase_in      = phase_ff;
      line_start_in = (c == CHAR_LF);

      if (req_ch.req_type == REQ_EOF) begin
         cmd.op        = CMD_EOF;
         produce       = 1'b1;
         phase_in      = PH_IDLE;
         line_start_in = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (c == CHAR_LF) phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               if (line_start_ff && c == CHAR_GT) begin
                  cmd.op   = CMD_CLOSE;
                  produce  = 1'b1;
                  phase_in = PH_HEADER;
               end else if (!is_space) begin
                  produce = 1'b1;
               end
            end
            default: begin
               if (line_start_ff && c == CHAR_GT) phase_in = PH_HEADER;
            end
         endcase
      end
   end

   assign push.push = accept && produce;
   assign push.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         line_start_ff <= 1'b1;
         check_ff      <= 1'b1;
      end else begin
         if (csr_we) check_ff <= csr_wdata;
         if (accept) begin
            phase_ff      <= phase_in;
            line_start_ff <= line_start_in;
         end
      end
   end

endmodule

// File: sv/frs_queue.sv
module frs_queue import frs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic                      do_push;
   logic                      do_pop;

   assign full       = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (QUEUE_PTR_BITS+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_PTR_BITS+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.cmd;
   end

endmodule

// File: sv/frs_back.sv
module frs_back import frs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   frs_rsp_if.source rsp_ch
);

   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] nongap_ff, nongap_in;
   logic [LENGTH_BITS-1:0] letters_ff, letters_in;
   logic [LENGTH_BITS-1:0] bases_ff, bases_in;
   logic [LENGTH_BITS-1:0] amb_ff, amb_in;
   logic                   sym_err_ff, sym_err_in;
   logic [INDEX_BITS-1:0]  records_ff, records_in;
   logic [LENGTH_BITS-1:0] shortest_ff, shortest_in;
   logic [LENGTH_BITS-1:0] longest_ff, longest_in;
   logic [INDEX_BITS-1:0]  short_idx_ff, short_idx_in;
   logic [INDEX_BITS-1:0]  long_idx_ff, long_idx_in;
   logic                   eof_split_ff, eof_split_in;

   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_status_ff, out_status_in;
   logic [INDEX_BITS-1:0]  out_index_ff, out_index_in;
   logic [LENGTH_BITS-1:0] out_len_ff, out_len_in;
   logic [LENGTH_BITS-1:0] out_nongap_ff, out_nongap_in;
   logic [LENGTH_BITS-1:0] out_letters_ff, out_letters_in;
   logic [LENGTH_BITS-1:0] out_bases_ff, out_bases_in;
   logic [LENGTH_BITS-1:0] out_amb_ff, out_amb_in;
   logic [LENGTH_BITS-1:0] out_min_ff, out_min_in;
   logic [LENGTH_BITS-1:0] out_max_ff, out_max_in;
   logic [INDEX_BITS-1:0]  out_min_idx_ff, out_min_idx_in;
   logic [INDEX_BITS-1:0]  out_max_idx_ff, out_max_idx_in;
   logic                   out_last_ff, out_last_in;

   logic out_free;
   logic emit_rec;
   logic emit_sum;
   logic do_count;
   logic shorter;
   logic longer;
   logic [LENGTH_BITS-1:0] min_new;
   logic [LENGTH_BITS-1:0] max_new;
   logic [INDEX_BITS-1:0]  min_idx_new;
   logic [INDEX_BITS-1:0]  max_idx_new;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      emit_rec = 1'b0;
      emit_sum = 1'b0;
      do_count = 1'b0;
      pop      = 1'b0;
      if (head.valid) begin
         unique case (head.cmd.op)
            CMD_COUNT: begin
               do_count = 1'b1;
               pop      = 1'b1;
            end
            CMD_CLOSE: begin
               emit_rec = out_free;
               pop      = out_free;
            end
            CMD_EOF: begin
               // open record: record beat first, summary beat on the next slot
               if (head.cmd.open && !eof_split_ff) begin
                  emit_rec = out_free;
               end else begin
                  emit_sum = out_free;
                  pop      = out_free;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      shorter     = (len_ff < shortest_ff);
      longer      = (len_ff > longest_ff);
      min_new     = shorter ? len_ff : shortest_ff;
      max_new     = longer ? len_ff : longest_ff;
      min_idx_new = shorter ? records_ff : short_idx_ff;
      max_idx_new = longer ? records_ff : long_idx_ff;

      len_in       = len_ff;
      nongap_in    = nongap_ff;
      letters_in   = letters_ff;
      bases_in     = bases_ff;
      amb_in       = amb_ff;
      sym_err_in   = sym_err_ff;
      records_in   = records_ff;
      shortest_in  = shortest_ff;
      longest_in   = longest_ff;
      short_idx_in = short_idx_ff;
      long_idx_in  = long_idx_ff;
      eof_split_in = eof_split_ff;

      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_status_in  = out_status_ff;
      out_index_in   = out_index_ff;
      out_len_in     = out_len_ff;
      out_nongap_in  = out_nongap_ff;
      out_letters_in = out_letters_ff;
      out_bases_in   = out_bases_ff;
      out_amb_in     = out_amb_ff;
      out_min_in     = out_min_ff;
      out_max_in     = out_max_ff;
      out_min_idx_in = out_min_idx_ff;
      out_max_idx_in = out_max_idx_ff;
      out_last_in    = out_last_ff;

      if (do_count) begin
         len_in = bump_len(len_ff);
         if (head.cmd.nongap) nongap_in = bump_len(nongap_ff);
         if (head.cmd.letter) letters_in = bump_len(letters_ff);
         if (head.cmd.letter && head.cmd.base) bases_in = bump_len(bases_ff);
         if (head.cmd.letter && head.cmd.amb) amb_in = bump_len(amb_ff);
         if (head.cmd.forbid) sym_err_in = 1'b1;
      end

      if (emit_rec) begin
         out_valid_in   = 1'b1;
         out_status_in  = sym_err_ff ? STATUS_SYMBOL : STATUS_OK;
         out_index_in   = records_ff;
         out_len_in     = len_ff;
         out_nongap_in  = nongap_ff;
         out_letters_in = letters_ff;
         out_bases_in   = bases_ff;
         out_amb_in     = amb_ff;
         out_min_in     = min_new;
         out_max_in     = max_new;
         out_min_idx_in = min_idx_new;
         out_max_idx_in = max_idx_new;
         out_last_in    = (head.cmd.op == CMD_CLOSE);

         shortest_in  = min_new;
         longest_in   = max_new;
         short_idx_in = min_idx_new;
         long_idx_in  = max_idx_new;
         records_in   = bump_idx(records_ff);
         len_in       = '0;
         nongap_in    = '0;
         letters_in   = '0;
         bases_in     = '0;
         amb_in       = '0;
         sym_err_in   = 1'b0;
         if (head.cmd.op == CMD_EOF) eof_split_in = 1'b1;
      end

      if (emit_sum) begin
         out_valid_in   = 1'b1;
         out_status_in  = STATUS_SUMMARY;
         out_index_in   = records_ff;
         out_len_in     = '0;
         out_nongap_in  = '0;
         out_letters_in = '0;
         out_bases_in   = '0;
         out_amb_in     = '0;
         out_min_in     = shortest_ff;
         out_max_in     = longest_ff;
         out_min_idx_in = short_idx_ff;
         out_max_idx_in = long_idx_ff;
         out_last_in    = 1'b1;

         // back to the start-of-file state
         len_in       = '0;
         nongap_in    = '0;
         letters_in   = '0;
         bases_in     = '0;
         amb_in       = '0;
         sym_err_in   = 1'b0;
         records_in   = '0;
         shortest_in  = '1;
         longest_in   = '0;
         short_idx_in = '0;
         long_idx_in  = '0;
         eof_split_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         nongap_ff    <= '0;
         letters_ff   <= '0;
         bases_ff     <= '0;
         amb_ff       <= '0;
         sym_err_ff   <= 1'b0;
         records_ff   <= '0;
         shortest_ff  <= '1;
         longest_ff   <= '0;
         short_idx_ff <= '0;
         long_idx_ff  <= '0;
         eof_split_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         nongap_ff    <= nongap_in;
         letters_ff   <= letters_in;
         bases_ff     <= bases_in;
         amb_ff       <= amb_in;
         sym_err_ff   <= sym_err_in;
         records_ff   <= records_in;
         shortest_ff  <= shortest_in;
         longest_ff   <= longest_in;
         short_idx_ff <= short_idx_in;
         long_idx_ff  <= long_idx_in;
         eof_split_ff <= eof_split_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_index_ff   <= out_index_in;
      out_len_ff     <= out_len_in;
      out_nongap_ff  <= out_nongap_in;
      out_letters_ff <= out_letters_in;
      out_bases_ff   <= out_bases_in;
      out_amb_ff     <= out_amb_in;
      out_min_ff     <= out_min_in;
      out_max_ff     <= out_max_in;
      out_min_idx_ff <= out_min_idx_in;
      out_max_idx_ff <= out_max_idx_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.status           = out_status_ff;
   assign rsp_ch.record_index     = out_index_ff;
   assign rsp_ch.seq_length       = out_len_ff;
   assign rsp_ch.nongap_length    = out_nongap_ff;
   assign rsp_ch.letter_count     = out_letters_ff;
   assign rsp_ch.nucleotide_count = out_bases_ff;
   assign rsp_ch.n_count          = out_amb_ff;
   assign rsp_ch.min_length       = out_min_ff;
   assign rsp_ch.max_length       = out_max_ff;
   assign rsp_ch.min_record       = out_min_idx_ff;
   assign rsp_ch.max_record       = out_max_idx_ff;
   assign rsp_ch.last             = out_last_ff;

endmodule

// File: sv/fasta_record_scanner_core.sv
// channel   dir  beat contents
// --------  ---  ------------------------------------------------------------
// req_ch    in   req_type (data / end of input), data_byte
// rsp_ch    out  status, record_index, five counts, min/max length and index, last
// csr_*     in   csr_we, csr_wdata -> check_symbols (resets to 1)
//
// One byte per cycle until the queue fills and req_ch.ready drops. The front
// classifies each byte and pushes only bytes that matter into a 4-entry command
// queue; the back drains one command per cycle unless a close or end of input
// waits on its single output register. An end of input in an open record sends
// a record beat, then a summary beat. Reset is synchronous; no clearing pass.
// rsp_ch stalls hold the output register; the back stops at the next result.
module fasta_record_scanner_core import frs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   frs_req_if.sink    req_ch,
   frs_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   push_type push;   // front -> queue
   head_type head;   // queue -> back
   logic     queue_full;
   logic     pop;

   // front: line tracking, header skipping, per-byte classification
   frs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push)
   );

   // decouples byte intake from result back-pressure
   frs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back: saturating counters, min/max tracking, result register
   frs_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
